### hdl/brro_pkg.sv
// brro_pkg: shared types, operation codes, sizes and the 64-bit population count
// for the bitmap rectangle raster-op block.
// No dependencies.
package brro_pkg;

    localparam int GRID_SIZE_DEF = 1024;
    localparam int COORD_IN_W    = 10;
    localparam int COUNT_OUT_W   = 21;
    localparam int WORD_W        = 64;
    localparam int DELTA_W       = 8;
    localparam logic [COUNT_OUT_W-1:0] COUNT_SAT = {COUNT_OUT_W{1'b1}};

    typedef logic [1:0] t_op;
    localparam t_op OP_SET    = 2'd0;
    localparam t_op OP_CLEAR  = 2'd1;
    localparam t_op OP_INVERT = 2'd2;

    // one word access issued to the memory
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [WORD_W-1:0] mask;
    } t_issue;

    // write-back from the modify stage
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] data;
    } t_wr;

    function automatic logic [6:0] pop64(input logic [WORD_W-1:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

### hdl/brro_ram.sv
// brro_ram: bitmap word memory, one write port and one read port,
// read data registered. Depends on brro_pkg.
module brro_ram import brro_pkg::*; #(
    parameter int DEPTH = GRID_SIZE_DEF * ((GRID_SIZE_DEF + WORD_W - 1) / WORD_W),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  logic              i_re,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/brro_rmw.sv
// brro_rmw: modify stage; applies the masked operation to the word read back,
// drives the write-back and registers the change in set-cell count. Depends on brro_pkg.
module brro_rmw import brro_pkg::*; #(
    parameter int AW = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_issue                    i_iss,
    input  logic [AW-1:0]             i_addr,
    input  logic [WORD_W-1:0]         i_rd_data,
    output t_wr                       o_wr,
    output logic [AW-1:0]             o_wr_addr,
    output logic                      o_delta_valid,
    output logic signed [DELTA_W-1:0] o_delta
);

    t_issue                    r_ctl;
    logic [AW-1:0]             r_addr;
    logic                      r_delta_valid;
    logic signed [DELTA_W-1:0] r_delta;

    logic [6:0]                n_on;
    logic [6:0]                n_mpop;
    logic [WORD_W-1:0]         n_word;
    logic signed [DELTA_W-1:0] n_delta;

    always_comb begin
        n_on   = pop64(i_rd_data & r_ctl.mask);
        n_mpop = pop64(r_ctl.mask);
        case (r_ctl.op)
            OP_SET: begin
                n_word  = i_rd_data | r_ctl.mask;
                n_delta = $signed({1'b0, n_mpop}) - $signed({1'b0, n_on});
            end
            OP_CLEAR: begin
                n_word  = i_rd_data & ~r_ctl.mask;
                n_delta = -$signed({1'b0, n_on});
            end
            default: begin
                n_word  = i_rd_data ^ r_ctl.mask;
                n_delta = $signed({1'b0, n_mpop}) - $signed({n_on, 1'b0});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid   <= 1'b0;
            r_delta_valid <= 1'b0;
        end else begin
            r_ctl.valid   <= i_iss.valid;
            r_delta_valid <= r_ctl.valid;
        end
        r_ctl.op   <= i_iss.op;
        r_ctl.mask <= i_iss.mask;
        r_addr     <= i_addr;
        r_delta    <= n_delta;
    end

    assign o_wr.valid    = r_ctl.valid;
    assign o_wr.data     = n_word;
    assign o_wr_addr     = r_addr;
    assign o_delta_valid = r_delta_valid;
    assign o_delta       = r_delta;

endmodule

### hdl/bitmap_rectangle_raster_op.sv
// bitmap_rectangle_raster_op: top level; sequencer, clear pass and set-cell count
// around the bitmap memory. Depends on brro_pkg, brro_ram, brro_rmw.
//
//  channel  | ports                                             | handshake
//  ---------+---------------------------------------------------+------------------------
//  request  | i_req_type, i_corner_a_x/y, i_corner_b_x/y        | start & !busy
//  result   | o_lit_count                                       | o_valid, one cycle
//
// An item covering R rows and W 64-bit words per row is swept word by word in S_RUN,
// then passes S_FLUSH and S_POST before the next transfer can be taken.
// The rate is one word read-modify-write per cycle through the two-port memory.
// An unused operation code skips the sweep and goes from S_IDLE to S_POST.
// After reset a clearing pass writes zero to every word, with busy high.
// The receiver cannot stall.
module bitmap_rectangle_raster_op import brro_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_req_type,
    input  logic [COORD_IN_W-1:0]  i_corner_a_x,
    input  logic [COORD_IN_W-1:0]  i_corner_a_y,
    input  logic [COORD_IN_W-1:0]  i_corner_b_x,
    input  logic [COORD_IN_W-1:0]  i_corner_b_y,
    output logic                   o_valid,
    output logic [COUNT_OUT_W-1:0] o_lit_count
);

    localparam int ROW_WORDS = (GRID_SIZE + WORD_W - 1) / WORD_W;
    localparam int DEPTH     = GRID_SIZE * ROW_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int EW        = (CW > COORD_IN_W) ? CW : COORD_IN_W;
    localparam int XW        = (CW > 6) ? CW : 7;
    localparam int WW        = XW - 6;
    localparam int CNTW      = $clog2(GRID_SIZE * GRID_SIZE + 1);
    localparam int SW        = (CNTW > COUNT_OUT_W) ? CNTW : COUNT_OUT_W;
    localparam int LW        = (CNTW > DELTA_W) ? CNTW : DELTA_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_POST
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_clr_addr;
    t_op                      r_op;
    logic [XW-1:0]            r_x0;
    logic [XW-1:0]            r_x1;
    logic [CW-1:0]            r_y;
    logic [CW-1:0]            r_y1;
    logic [WW-1:0]            r_w;
    logic [CNTW-1:0]          r_cnt;
    logic                     r_valid;
    logic [COUNT_OUT_W-1:0]   r_lit_count;

    logic [CW-1:0]            n_ax, n_ay, n_bx, n_by;
    logic [5:0]               n_lo, n_hi;
    logic [WORD_W-1:0]        n_mask;
    logic [AW-1:0]            n_rd_addr;
    logic [LW-1:0]            n_sum;
    logic [CNTW-1:0]          n_cnt;
    logic [SW-1:0]            n_cnt_ext;
    logic [COUNT_OUT_W-1:0]   n_lit;
    t_issue                   iss;
    t_wr                      rmw_wr;
    logic [AW-1:0]            rmw_wr_addr;
    logic                     delta_valid;
    logic signed [DELTA_W-1:0] delta;
    logic                     mem_we;
    logic [AW-1:0]            mem_wr_addr;
    logic [WORD_W-1:0]        mem_wr_data;
    logic [WORD_W-1:0]        mem_rd_data;
    logic                     accept;

    function automatic logic [CW-1:0] clamp(input logic [COORD_IN_W-1:0] c);
        logic [EW-1:0] e;
        e = EW'(c);
        if (e > EW'(GRID_SIZE - 1)) e = EW'(GRID_SIZE - 1);
        return e[CW-1:0];
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_ax = clamp(i_corner_a_x);
        n_ay = clamp(i_corner_a_y);
        n_bx = clamp(i_corner_b_x);
        n_by = clamp(i_corner_b_y);
    end

    // word mask and address for the current sweep position
    always_comb begin
        n_lo      = (r_w == r_x0[XW-1:6]) ? r_x0[5:0] : 6'd0;
        n_hi      = (r_w == r_x1[XW-1:6]) ? r_x1[5:0] : 6'd63;
        n_mask    = ({WORD_W{1'b1}} << n_lo) & ({WORD_W{1'b1}} >> (6'd63 - n_hi));
        n_rd_addr = AW'(r_y * ROW_WORDS) + AW'(r_w);
        iss.valid = (r_state == S_RUN);
        iss.op    = r_op;
        iss.mask  = n_mask;
    end

    always_comb begin
        n_sum     = LW'(r_cnt) + LW'(delta);
        n_cnt     = delta_valid ? n_sum[CNTW-1:0] : r_cnt;
        n_cnt_ext = SW'(n_cnt);
        n_lit     = (n_cnt_ext > SW'(COUNT_SAT)) ? COUNT_SAT : n_cnt_ext[COUNT_OUT_W-1:0];
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we      = 1'b1;
            mem_wr_addr = r_clr_addr;
            mem_wr_data = '0;
        end else begin
            mem_we      = rmw_wr.valid;
            mem_wr_addr = rmw_wr_addr;
            mem_wr_data = rmw_wr.data;
        end
    end

    brro_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_re      (iss.valid),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    brro_rmw #(
        .AW (AW)
    ) u_rmw (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_iss         (iss),
        .i_addr        (n_rd_addr),
        .i_rd_data     (mem_rd_data),
        .o_wr          (rmw_wr),
        .o_wr_addr     (rmw_wr_addr),
        .o_delta_valid (delta_valid),
        .o_delta       (delta)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op <= i_req_type;
                        r_x0 <= XW'((n_ax < n_bx) ? n_ax : n_bx);
                        r_x1 <= XW'((n_ax < n_bx) ? n_bx : n_ax);
                        r_y  <= (n_ay < n_by) ? n_ay : n_by;
                        r_y1 <= (n_ay < n_by) ? n_by : n_ay;
                        r_w  <= WW'(XW'((n_ax < n_bx) ? n_ax : n_bx) >> 6);
                        if (i_req_type == OP_SET || i_req_type == OP_CLEAR
                                || i_req_type == OP_INVERT) begin
                            r_state <= S_RUN;
                        end else begin
                            r_state <= S_POST;
                        end
                    end
                end
                S_RUN: begin
                    if (r_w == r_x1[XW-1:6]) begin
                        r_w <= r_x0[XW-1:6];
                        if (r_y == r_y1) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_y <= r_y + 1'b1;
                        end
                    end else begin
                        r_w <= r_w + 1'b1;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_lit_count <= n_lit;
                    r_valid     <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_lit_count = r_lit_count;

    a_valid_after_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_POST)
        else $error("result strobe without a finished sweep");

    a_no_rmw_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !rmw_wr.valid && !delta_valid)
        else $error("modify stage active during clearing pass");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !rmw_wr.valid && !delta_valid)
        else $error("pipeline not drained when idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(GRID_SIZE * GRID_SIZE))
        else $error("set-cell count beyond grid area");

endmodule
